### sv/sm3_hash_stream_defines.svh
// Assertion macros for the SM3 hash stream block.
`ifndef SM3_HASH_STREAM_DEFINES_SVH
`define SM3_HASH_STREAM_DEFINES_SVH
`ifndef SYNTH
`define SM3_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SM3_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SM3_ASSERT(label, clk, rst, prop, msg)
`define SM3_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### sv/sm3_pkg.sv
// Shared types and constants for the SM3 hash stream block.
`timescale 1ns / 1ps
package sm3_pkg;
  localparam logic [31:0] T_LOW = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam int QDEPTH = 4;

  // queue entry: one word for the core plus a flag that marks the digest point
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } qword_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    p0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    p1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage

### sv/sm3_hash_stream.sv
// SM3 hash stream block: top level.
// Input stream s_*: one 32-bit big-endian message word per transfer; tlast marks
// the final word of a message, and tdata[34:32] gives its valid leading bytes
// (0..4, above 4 taken as 4; ignored on non-final words).
// Output stream m_*: eight transfers per message carry the 256-bit digest,
// word 0 first; tlast is high on the eighth word.
// A front end counts bytes and generates padding and length words; a four-entry
// queue decouples it from the compression core. The core loads 16 words, one per
// cycle while the queue has words, then runs 64 rounds, one round per cycle; the
// input stalls whenever the queue is full. After the final word, padding takes
// one or two blocks, and the first digest word appears once the core has run
// the last of them, after finishing any block that was still running.
// Digest words hold while m_tready is low; the core stalls and back-pressure
// reaches the input through the queue.
// Reset (rst, synchronous, active high) restores the initial vector and clears
// all counters; a message in progress is dropped.
`timescale 1ns / 1ps
`include "sm3_hash_stream_defines.svh"
module sm3_hash_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero fill
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast
);
  sm3_pkg::qword_t fq_data;
  sm3_pkg::qword_t qc_data;
  logic fq_valid;
  logic fq_ready;
  logic qc_valid;
  logic qc_ready;

  sm3_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  sm3_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
    .out_valid(qc_valid), .out_ready(qc_ready), .out_data(qc_data)
  );

  sm3_core u_core (
    .clk(clk), .rst(rst), .q_valid(qc_valid), .q_ready(qc_ready), .q_data(qc_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  `SM3_ASSERT(a_last_idx, clk, rst, (m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd7), "bad idx")
  `SM3_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "hold")
  `SM3_ASSERT_NR(a_rst, clk, rst |=> !m_tvalid, "output valid after reset")
endmodule

### sv/sm3_front.sv
// Front end: accepts message words, tracks length, generates padding words.
`timescale 1ns / 1ps
module sm3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,
  input  logic              s_tlast,
  output logic              q_valid,
  input  logic              q_ready,
  output sm3_pkg::qword_t   q_data
);
  localparam logic [1:0] ST_TAKE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_LENH = 2'd2;
  localparam logic [1:0] ST_LENL = 2'd3;

  logic [1:0]  state;
  logic [60:0] total;
  logic [3:0]  fill;
  logic        pend;
  logic [31:0] word_in;
  logic [2:0]  cnt_raw;
  logic [2:0]  n;
  logic [31:0] keep;
  logic [31:0] padded;
  logic [63:0] bits;
  logic        push;

  assign word_in = s_tdata[31:0];
  assign cnt_raw = s_tdata[34:32];
  assign n = (cnt_raw > 3'd4) ? 3'd4 : cnt_raw;
  assign bits = {total, 3'b000};
  assign push = q_valid && q_ready;

  always_comb begin
    keep = 32'hFFFFFFFF;
    padded = word_in;
    unique case (n)
      3'd0: begin keep = 32'h0;        padded = sm3_pkg::PAD_WORD; end
      3'd1: begin keep = 32'hFF000000; padded = (word_in & keep) | 32'h00800000; end
      3'd2: begin keep = 32'hFFFF0000; padded = (word_in & keep) | 32'h00008000; end
      3'd3: begin keep = 32'hFFFFFF00; padded = (word_in & keep) | 32'h00000080; end
      default: begin keep = 32'hFFFFFFFF; padded = word_in; end
    endcase
  end

  assign s_tready = (state == ST_TAKE) && !pend && q_ready;

  always_comb begin
    q_valid = 1'b0;
    q_data = '{word: 32'h0, last: 1'b0};
    unique case (state)
      ST_TAKE: begin
        if (pend) begin
          q_valid = 1'b1;
          q_data.word = sm3_pkg::PAD_WORD;
        end else if (s_tvalid) begin
          q_valid = 1'b1;
          q_data.word = (s_tlast) ? padded : word_in;
        end
      end
      ST_ZERO: q_valid = 1'b1;
      ST_LENH: begin q_valid = 1'b1; q_data.word = bits[63:32]; end
      default: begin q_valid = 1'b1; q_data.word = bits[31:0]; q_data.last = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
      total <= '0;
      fill <= '0;
      pend <= 1'b0;
    end else if (push) begin
      fill <= fill + 4'd1;
      unique case (state)
        ST_TAKE: begin
          if (pend) begin
            pend <= 1'b0;
            state <= (fill == 4'd13) ? ST_LENH : ST_ZERO;
          end else if (!s_tlast) begin
            total <= total + 61'd4;
          end else begin
            total <= total + {58'd0, n};
            if (n == 3'd4) pend <= 1'b1;
            else state <= (fill == 4'd13) ? ST_LENH : ST_ZERO;
          end
        end
        ST_ZERO: if (fill == 4'd13) state <= ST_LENH;
        ST_LENH: state <= ST_LENL;
        default: begin
          state <= ST_TAKE;
          total <= '0;
        end
      endcase
    end
  end
endmodule

### sv/sm3_queue.sv
// Small FIFO between the front end and the compression core.
`timescale 1ns / 1ps
module sm3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sm3_pkg::qword_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sm3_pkg::qword_t out_data
);
  localparam int AW = $clog2(sm3_pkg::QDEPTH);
  sm3_pkg::qword_t mem [sm3_pkg::QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic wr;
  logic rd;

  assign in_ready = count != (AW+1)'(sm3_pkg::QDEPTH);
  assign out_valid = count != '0;
  assign out_data = mem[rptr];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
    end
  end
endmodule

### sv/sm3_core.sv
// Back end: block buffer, 64-round compression, digest output.
`timescale 1ns / 1ps
module sm3_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  sm3_pkg::qword_t q_data,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic            m_tlast
);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state;
  logic [31:0] buf_w [16];
  logic [31:0] win [16];
  logic [31:0] r [8];
  logic [255:0] chain;
  logic [3:0]  fill;
  logic [5:0]  rnd;
  logic        emit;
  logic [2:0]  oidx;
  logic [31:0] w_new;
  logic [31:0] wj;
  logic [31:0] wj4;
  logic [31:0] tj;
  logic [31:0] a12;
  logic [31:0] ss1;
  logic [31:0] ss2;
  logic [31:0] ff;
  logic [31:0] gg;
  logic [31:0] tt1;
  logic [31:0] tt2;

  // window shifts each round: win[k] holds W[j+k]
  always_comb begin
    w_new = sm3_pkg::p1(win[0] ^ win[7] ^ sm3_pkg::rotl(win[13], 5'd15))
            ^ sm3_pkg::rotl(win[3], 5'd7) ^ win[10];
    wj = win[0];
    wj4 = win[4];
    tj = (rnd < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rotl(r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r[4] + sm3_pkg::rotl(tj, rnd[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r[7] + ss1 + wj;
  end

  assign q_ready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {5'd0, oidx, chain[255 - 32*oidx -: 32]};
  assign m_tlast = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && q_valid) buf_w[fill] <= q_data.word;
    if (state == ST_RUN) begin
      for (int k = 0; k < 15; k++) win[k] <= win[k+1];
      win[15] <= w_new;
      r[0] <= tt1;
      r[1] <= r[0];
      r[2] <= sm3_pkg::rotl(r[1], 5'd9);
      r[3] <= r[2];
      r[4] <= sm3_pkg::p0(tt2);
      r[5] <= r[4];
      r[6] <= sm3_pkg::rotl(r[5], 5'd19);
      r[7] <= r[6];
    end else if (state == ST_LOAD && q_valid && fill == 4'd15) begin
      for (int k = 0; k < 15; k++) win[k] <= buf_w[k];
      win[15] <= q_data.word;
      for (int k = 0; k < 8; k++) r[k] <= chain[255 - 32*k -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill <= '0;
      rnd <= '0;
      emit <= 1'b0;
      oidx <= '0;
      chain <= sm3_pkg::IV;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (q_valid) begin
            fill <= fill + 4'd1;
            if (fill == 4'd15) begin
              state <= ST_RUN;
              emit <= q_data.last;
              rnd <= '0;
            end
          end
        end
        ST_RUN: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            chain <= chain ^ {tt1, r[0], sm3_pkg::rotl(r[1], 5'd9), r[2],
                              sm3_pkg::p0(tt2), r[4], sm3_pkg::rotl(r[5], 5'd19), r[6]};
            state <= emit ? ST_OUT : ST_LOAD;
            oidx <= '0;
          end
        end
        default: begin
          if (m_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= ST_LOAD;
              chain <= sm3_pkg::IV;
            end
          end
        end
      endcase
    end
  end
endmodule
